[src/trx_pkg.sv]
// Package for the table XOR random generator: payload types and the four
// constant 256-word lookup tables. Depends on nothing.
package trx_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned ByteW = 8;
	localparam int unsigned Lanes = 4;
	localparam int unsigned TabDepth = 256;

	typedef logic [WordW-1:0] word_t;
	typedef logic [ByteW-1:0] byte_t;

	// Payload of one division stage: partial remainder, dividend bits not yet
	// consumed (MSB first), divisor and the zero-divisor flag.
	typedef struct packed {
		word_t rem;
		word_t num;
		word_t modulus;
		logic  bad;
	} div_t;

	localparam word_t TAB0 [TabDepth] = '{
		32'd251291136, 32'd3952231631, 32'd3370958628, 32'd4070167936, 32'd123631495,
		32'd3351110283, 32'd3218676425, 32'd2011642291, 32'd774603218, 32'd2402805061,
		32'd1004366930, 32'd1843948209, 32'd428891132, 32'd3746331984, 32'd1591258008,
		32'd3067016507, 32'd1433388735, 32'd504005498, 32'd2032657933, 32'd3419319784,
		32'd2805686246, 32'd3102436986, 32'd3808671154, 32'd2501582075, 32'd3978944421,
		32'd246043949, 32'd4016898363, 32'd649743608, 32'd1974987508, 32'd2651273766,
		32'd2357956801, 32'd689605112, 32'd715807172, 32'd2722736134, 32'd191939188,
		32'd3535520147, 32'd3277019569, 32'd1470435941, 32'd3763101702, 32'd3232409631,
		32'd122701163, 32'd3920852693, 32'd782246947, 32'd372121310, 32'd2995604341,
		32'd2045698575, 32'd2332962102, 32'd4005368743, 32'd218596347, 32'd3415381967,
		32'd4207612806, 32'd861117671, 32'd3676575285, 32'd2581671944, 32'd3312220480,
		32'd681232419, 32'd307306866, 32'd4112503940, 32'd1158111502, 32'd709227802,
		32'd2724140433, 32'd4201101115, 32'd4215970289, 32'd4048876515, 32'd3031661061,
		32'd1909085522, 32'd510985033, 32'd1361682810, 32'd129243379, 32'd3142379587,
		32'd2569842483, 32'd3033268270, 32'd1658118006, 32'd932109358, 32'd1982290045,
		32'd2983082771, 32'd3007670818, 32'd3448104768, 32'd683749698, 32'd778296777,
		32'd1399125101, 32'd1939403708, 32'd1692176003, 32'd3868299200, 32'd1422476658,
		32'd593093658, 32'd1878973865, 32'd2526292949, 32'd1591602827, 32'd3986158854,
		32'd3964389521, 32'd2695031039, 32'd1942050155, 32'd424618399, 32'd1347204291,
		32'd2669179716, 32'd2434425874, 32'd2540801947, 32'd1384069776, 32'd4123580443,
		32'd1523670218, 32'd2708475297, 32'd1046771089, 32'd2229796016, 32'd1255426612,
		32'd4213663089, 32'd1521339547, 32'd3041843489, 32'd420130494, 32'd10677091,
		32'd515623176, 32'd3457502702, 32'd2115821274, 32'd2720124766, 32'd3242576090,
		32'd854310108, 32'd425973987, 32'd325832382, 32'd1796851292, 32'd2462744411,
		32'd1976681690, 32'd1408671665, 32'd1228817808, 32'd3917210003, 32'd263976645,
		32'd2593736473, 32'd2471651269, 32'd4291353919, 32'd650792940, 32'd1191583883,
		32'd3046561335, 32'd2466530435, 32'd2545983082, 32'd969168436, 32'd2019348792,
		32'd2268075521, 32'd1169345068, 32'd3250240009, 32'd3963499681, 32'd2560755113,
		32'd911182396, 32'd760842409, 32'd3569308693, 32'd2687243553, 32'd381854665,
		32'd2613828404, 32'd2761078866, 32'd1456668111, 32'd883760091, 32'd3294951678,
		32'd1604598575, 32'd1985308198, 32'd1014570543, 32'd2724959607, 32'd3062518035,
		32'd3115293053, 32'd138853680, 32'd4160398285, 32'd3322241130, 32'd2068983570,
		32'd2247491078, 32'd3669524410, 32'd1575146607, 32'd828029864, 32'd3732001371,
		32'd3422026452, 32'd3370954177, 32'd4006626915, 32'd543812220, 32'd1243116171,
		32'd3928372514, 32'd2791443445, 32'd4081325272, 32'd2280435605, 32'd885616073,
		32'd616452097, 32'd3188863436, 32'd2780382310, 32'd2340014831, 32'd1208439576,
		32'd258356309, 32'd3837963200, 32'd2075009450, 32'd3214181212, 32'd3303882142,
		32'd880813252, 32'd1355575717, 32'd207231484, 32'd2420803184, 32'd358923368,
		32'd1617557768, 32'd3272161958, 32'd1771154147, 32'd2842106362, 32'd1751209208,
		32'd1421030790, 32'd658316681, 32'd194065839, 32'd3241510581, 32'd38625260,
		32'd301875395, 32'd4176141739, 32'd297312930, 32'd2137802113, 32'd1502984205,
		32'd3669376622, 32'd3728477036, 32'd234652930, 32'd2213589897, 32'd2734638932,
		32'd1129721478, 32'd3187422815, 32'd2859178611, 32'd3284308411, 32'd3819792700,
		32'd3557526733, 32'd451874476, 32'd1740576081, 32'd3592838701, 32'd1709429513,
		32'd3702918379, 32'd3533351328, 32'd1641660745, 32'd179350258, 32'd2380520112,
		32'd3936163904, 32'd3685256204, 32'd3156252216, 32'd1854258901, 32'd2861641019,
		32'd3176611298, 32'd834787554, 32'd331353807, 32'd517858103, 32'd3010168884,
		32'd4012642001, 32'd2217188075, 32'd3756943137, 32'd3077882590, 32'd2054995199,
		32'd3081443129, 32'd3895398812, 32'd1141097543, 32'd2376261053, 32'd2626898255,
		32'd2554703076, 32'd401233789, 32'd1460049922, 32'd678083952, 32'd1064990737,
		32'd940909784, 32'd1673396780, 32'd528881783, 32'd1712547446, 32'd3629685652,
		32'd1358307511
	};

	localparam word_t TAB1 [TabDepth] = '{
		32'd807385413, 32'd2043073223, 32'd3336749796, 32'd1302105833, 32'd2278607931,
		32'd541015020, 32'd1684564270, 32'd372709334, 32'd3508252125, 32'd1768346005,
		32'd1270451292, 32'd2603029534, 32'd2049387273, 32'd3891424859, 32'd2152948345,
		32'd4114760273, 32'd915180310, 32'd3754787998, 32'd700503826, 32'd2131559305,
		32'd1308908630, 32'd224437350, 32'd4065424007, 32'd3638665944, 32'd1679385496,
		32'd3431345226, 32'd1779595665, 32'd3068494238, 32'd1424062773, 32'd1033448464,
		32'd4050396853, 32'd3302235057, 32'd420600373, 32'd2868446243, 32'd311689386,
		32'd259047959, 32'd4057180909, 32'd1575367248, 32'd4151214153, 32'd110249784,
		32'd3006865921, 32'd4293710613, 32'd3501256572, 32'd998007483, 32'd499288295,
		32'd1205710710, 32'd2997199489, 32'd640417429, 32'd3044194711, 32'd486690751,
		32'd2686640734, 32'd2394526209, 32'd2521660077, 32'd49993987, 32'd3843885867,
		32'd4201106668, 32'd415906198, 32'd19296841, 32'd2402488407, 32'd2137119134,
		32'd1744097284, 32'd579965637, 32'd2037662632, 32'd852173610, 32'd2681403713,
		32'd1047144830, 32'd2982173936, 32'd910285038, 32'd4187576520, 32'd2589870048,
		32'd989448887, 32'd3292758024, 32'd506322719, 32'd176010738, 32'd1865471968,
		32'd2619324712, 32'd564829442, 32'd1996870325, 32'd339697593, 32'd4071072948,
		32'd3618966336, 32'd2111320126, 32'd1093955153, 32'd957978696, 32'd892010560,
		32'd1854601078, 32'd1873407527, 32'd2498544695, 32'd2694156259, 32'd1927339682,
		32'd1650555729, 32'd183933047, 32'd3061444337, 32'd2067387204, 32'd228962564,
		32'd3904109414, 32'd1595995433, 32'd1780701372, 32'd2463145963, 32'd307281463,
		32'd3237929991, 32'd3852995239, 32'd2398693510, 32'd3754138664, 32'd522074127,
		32'd146352474, 32'd4104915256, 32'd3029415884, 32'd3545667983, 32'd332038910,
		32'd976628269, 32'd3123492423, 32'd3041418372, 32'd2258059298, 32'd2139377204,
		32'd3243642973, 32'd3226247917, 32'd3674004636, 32'd2698992189, 32'd3453843574,
		32'd1963216666, 32'd3509855005, 32'd2358481858, 32'd747331248, 32'd1957348676,
		32'd1097574450, 32'd2435697214, 32'd3870972145, 32'd1888833893, 32'd2914085525,
		32'd4161315584, 32'd1273113343, 32'd3269644828, 32'd3681293816, 32'd412536684,
		32'd1156034077, 32'd3823026442, 32'd1066971017, 32'd3598330293, 32'd1979273937,
		32'd2079029895, 32'd1195045909, 32'd1071986421, 32'd2712821515, 32'd3377754595,
		32'd2184151095, 32'd750918864, 32'd2585729879, 32'd4249895712, 32'd1832579367,
		32'd1192240192, 32'd946734366, 32'd31230688, 32'd3174399083, 32'd3549375728,
		32'd1642430184, 32'd1904857554, 32'd861877404, 32'd3277825584, 32'd4267074718,
		32'd3122860549, 32'd666423581, 32'd644189126, 32'd226475395, 32'd307789415,
		32'd1196105631, 32'd3191691839, 32'd782852669, 32'd1608507813, 32'd1847685900,
		32'd4069766876, 32'd3931548641, 32'd2526471011, 32'd766865139, 32'd2115084288,
		32'd4259411376, 32'd3323683436, 32'd568512177, 32'd3736601419, 32'd1800276898,
		32'd4012458395, 32'd1823982, 32'd27980198, 32'd2023839966, 32'd869505096,
		32'd431161506, 32'd1024804023, 32'd1853869307, 32'd3393537983, 32'd1500703614,
		32'd3019471560, 32'd1351086955, 32'd3096933631, 32'd3034634988, 32'd2544598006,
		32'd1230942551, 32'd3362230798, 32'd159984793, 32'd491590373, 32'd3993872886,
		32'd3681855622, 32'd903593547, 32'd3535062472, 32'd1799803217, 32'd772984149,
		32'd895863112, 32'd1899036275, 32'd4187322100, 32'd101856048, 32'd234650315,
		32'd3183125617, 32'd3190039692, 32'd525584357, 32'd1286834489, 32'd455810374,
		32'd1869181575, 32'd922673938, 32'd3877430102, 32'd3422391938, 32'd1414347295,
		32'd1971054608, 32'd3061798054, 32'd830555096, 32'd2822905141, 32'd167033190,
		32'd1079139428, 32'd4210126723, 32'd3593797804, 32'd429192890, 32'd372093950,
		32'd1779187770, 32'd3312189287, 32'd204349348, 32'd452421568, 32'd2800540462,
		32'd3733109044, 32'd1235082423, 32'd1765319556, 32'd3174729780, 32'd3762994475,
		32'd3171962488, 32'd442160826, 32'd198349622, 32'd45942637, 32'd1324086311,
		32'd2901868599, 32'd678860040, 32'd3812229107, 32'd19936821, 32'd1119590141,
		32'd3640121682, 32'd3545931032, 32'd2102949142, 32'd2828208598, 32'd3603378023,
		32'd4135048896
	};

	localparam word_t TAB2 [TabDepth] = '{
		32'd1629829892, 32'd282540176, 32'd2794583710, 32'd496504798, 32'd2990494426,
		32'd3070701851, 32'd2575963183, 32'd4094823972, 32'd2775723650, 32'd4079480416,
		32'd176028725, 32'd2246241423, 32'd3732217647, 32'd2196843075, 32'd1306949278,
		32'd4170992780, 32'd4039345809, 32'd3209664269, 32'd3387499533, 32'd293063229,
		32'd3660290503, 32'd2648440860, 32'd2531406539, 32'd3537879412, 32'd773374739,
		32'd4184691853, 32'd1804207821, 32'd3347126643, 32'd3479377103, 32'd3970515774,
		32'd1891731298, 32'd2368003842, 32'd3537588307, 32'd2969158410, 32'd4230745262,
		32'd831906319, 32'd2935838131, 32'd264029468, 32'd120852739, 32'd3200326460,
		32'd355445271, 32'd2296305141, 32'd1566296040, 32'd1760127056, 32'd20073893,
		32'd3427103620, 32'd2866979760, 32'd2359075957, 32'd2025314291, 32'd1725696734,
		32'd3346087406, 32'd2690756527, 32'd99815156, 32'd4248519977, 32'd2253762642,
		32'd3274144518, 32'd598024568, 32'd3299672435, 32'd556579346, 32'd4121041856,
		32'd2896948975, 32'd3620123492, 32'd918453629, 32'd3249461198, 32'd2231414958,
		32'd3803272287, 32'd3657597946, 32'd2588911389, 32'd242262274, 32'd1725007475,
		32'd2026427718, 32'd46776484, 32'd2873281403, 32'd2919275846, 32'd3177933051,
		32'd1918859160, 32'd2517854537, 32'd1857818511, 32'd3234262050, 32'd479353687,
		32'd200201308, 32'd2801945841, 32'd1621715769, 32'd483977159, 32'd423502325,
		32'd3689396064, 32'd1850168397, 32'd3359959416, 32'd3459831930, 32'd841488699,
		32'd3570506095, 32'd930267420, 32'd1564520841, 32'd2505122797, 32'd593824107,
		32'd1116572080, 32'd819179184, 32'd3139123629, 32'd1414339336, 32'd1076360795,
		32'd512403845, 32'd177759256, 32'd1701060666, 32'd2239736419, 32'd515179302,
		32'd2935012727, 32'd3821357612, 32'd1376520851, 32'd2700745271, 32'd966853647,
		32'd1041862223, 32'd715860553, 32'd171592961, 32'd1607044257, 32'd1227236688,
		32'd3647136358, 32'd1417559141, 32'd4087067551, 32'd2241705880, 32'd4194136288,
		32'd1439041934, 32'd20464430, 32'd119668151, 32'd2021257232, 32'd2551262694,
		32'd1381539058, 32'd4082839035, 32'd498179069, 32'd311508499, 32'd3580908637,
		32'd2889149671, 32'd142719814, 32'd1232184754, 32'd3356662582, 32'd2973775623,
		32'd1469897084, 32'd1728205304, 32'd1415793613, 32'd50111003, 32'd3133413359,
		32'd4074115275, 32'd2710540611, 32'd2700083070, 32'd2457757663, 32'd2612845330,
		32'd3775943755, 32'd2469309260, 32'd2560142753, 32'd3020996369, 32'd1691667711,
		32'd4219602776, 32'd1687672168, 32'd1017921622, 32'd2307642321, 32'd368711460,
		32'd3282925988, 32'd213208029, 32'd4150757489, 32'd3443211944, 32'd2846101972,
		32'd4106826684, 32'd4272438675, 32'd2199416468, 32'd3710621281, 32'd497564971,
		32'd285138276, 32'd765042313, 32'd916220877, 32'd3402623607, 32'd2768784621,
		32'd1722849097, 32'd3386397442, 32'd487920061, 32'd3569027007, 32'd3424544196,
		32'd217781973, 32'd2356938519, 32'd3252429414, 32'd145109750, 32'd2692588106,
		32'd2454747135, 32'd1299493354, 32'd4120241887, 32'd2088917094, 32'd932304329,
		32'd1442609203, 32'd952586974, 32'd3509186750, 32'd753369054, 32'd854421006,
		32'd1954046388, 32'd2708927882, 32'd4047539230, 32'd3048925996, 32'd1667505809,
		32'd805166441, 32'd1182069088, 32'd4265546268, 32'd4215029527, 32'd3374748959,
		32'd373532666, 32'd2454243090, 32'd2371530493, 32'd3651087521, 32'd2619878153,
		32'd1651809518, 32'd1553646893, 32'd1227452842, 32'd703887512, 32'd3696674163,
		32'd2552507603, 32'd2635912901, 32'd895130484, 32'd3287782244, 32'd3098973502,
		32'd990078774, 32'd3780326506, 32'd2290845203, 32'd41729428, 32'd1949580860,
		32'd2283959805, 32'd1036946170, 32'd1694887523, 32'd4880696, 32'd466000198,
		32'd2765355283, 32'd3318686998, 32'd1266458025, 32'd3919578154, 32'd3545413527,
		32'd2627009988, 32'd3744680394, 32'd1696890173, 32'd3250684705, 32'd4142417708,
		32'd915739411, 32'd3308488877, 32'd1289361460, 32'd2942552331, 32'd1169105979,
		32'd3342228712, 32'd698560958, 32'd1356041230, 32'd2401944293, 32'd107705232,
		32'd3701895363, 32'd903928723, 32'd3646581385, 32'd844950914, 32'd1944371367,
		32'd3863894844, 32'd2946773319, 32'd1972431613, 32'd1706989237, 32'd29917467,
		32'd3497665928
	};

	localparam word_t TAB3 [TabDepth] = '{
		32'd1191369816, 32'd744902811, 32'd2539772235, 32'd3213192037, 32'd3286061266,
		32'd1200571165, 32'd2463281260, 32'd754888894, 32'd714651270, 32'd1968220972,
		32'd3628497775, 32'd1277626456, 32'd1493398934, 32'd364289757, 32'd2055487592,
		32'd3913468088, 32'd2930259465, 32'd902504567, 32'd3967050355, 32'd2056499403,
		32'd692132390, 32'd186386657, 32'd832834706, 32'd859795816, 32'd1283120926,
		32'd2253183716, 32'd3003475205, 32'd1755803552, 32'd2239315142, 32'd4271056352,
		32'd2184848469, 32'd769228092, 32'd1249230754, 32'd1193269205, 32'd2660094102,
		32'd642979613, 32'd1687087994, 32'd2726106182, 32'd446402913, 32'd4122186606,
		32'd3771347282, 32'd37667136, 32'd192775425, 32'd3578702187, 32'd1952659096,
		32'd3989584400, 32'd3069013882, 32'd2900516158, 32'd4045316336, 32'd3057163251,
		32'd1702104819, 32'd4116613420, 32'd3575472384, 32'd2674023117, 32'd1409126723,
		32'd3215095429, 32'd1430726429, 32'd2544497368, 32'd1029565676, 32'd1855801827,
		32'd4262184627, 32'd1854326881, 32'd2906728593, 32'd3277836557, 32'd2787697002,
		32'd2787333385, 32'd3105430738, 32'd2477073192, 32'd748038573, 32'd1088396515,
		32'd1611204853, 32'd201964005, 32'd3745818380, 32'd3654683549, 32'd3816120877,
		32'd3915783622, 32'd2563198722, 32'd1181149055, 32'd33158084, 32'd3723047845,
		32'd3790270906, 32'd3832415204, 32'd2959617497, 32'd372900708, 32'd1286738499,
		32'd1932439099, 32'd3677748309, 32'd2454711182, 32'd2757856469, 32'd2134027055,
		32'd2780052465, 32'd3190347618, 32'd3758510138, 32'd3626329451, 32'd1120743107,
		32'd1623585693, 32'd1389834102, 32'd2719230375, 32'd3038609003, 32'd462617590,
		32'd260254189, 32'd3706349764, 32'd2556762744, 32'd2874272296, 32'd2502399286,
		32'd4216263978, 32'd2683431180, 32'd2168560535, 32'd3561507175, 32'd668095726,
		32'd680412330, 32'd3726693946, 32'd4180630637, 32'd3335170953, 32'd942140968,
		32'd2711851085, 32'd2059233412, 32'd4265696278, 32'd3204373534, 32'd232855056,
		32'd881788313, 32'd2258252172, 32'd2043595984, 32'd3758795150, 32'd3615341325,
		32'd2138837681, 32'd1351208537, 32'd2923692473, 32'd3402482785, 32'd2105383425,
		32'd2346772751, 32'd499245323, 32'd3417846006, 32'd2366116814, 32'd2543090583,
		32'd1828551634, 32'd3148696244, 32'd3853884867, 32'd1364737681, 32'd2200687771,
		32'd2689775688, 32'd232720625, 32'd4071657318, 32'd2671968983, 32'd3531415031,
		32'd1212852141, 32'd867923311, 32'd3740109711, 32'd1923146533, 32'd3237071777,
		32'd3100729255, 32'd3247856816, 32'd906742566, 32'd4047640575, 32'd4007211572,
		32'd3495700105, 32'd1171285262, 32'd2835682655, 32'd1634301229, 32'd3115169925,
		32'd2289874706, 32'd2252450179, 32'd944880097, 32'd371933491, 32'd1649074501,
		32'd2208617414, 32'd2524305981, 32'd2496569844, 32'd2667037160, 32'd1257550794,
		32'd3399219045, 32'd3194894295, 32'd1643249887, 32'd342911473, 32'd891025733,
		32'd3146861835, 32'd3789181526, 32'd938847812, 32'd1854580183, 32'd2112653794,
		32'd2960702988, 32'd1238603378, 32'd2205280635, 32'd1666784014, 32'd2520274614,
		32'd3355493726, 32'd2310872278, 32'd3153920489, 32'd2745882591, 32'd1200203158,
		32'd3033612415, 32'd2311650167, 32'd1048129133, 32'd4206710184, 32'd4209176741,
		32'd2640950279, 32'd2096382177, 32'd4116899089, 32'd3631017851, 32'd4104488173,
		32'd1857650503, 32'd3801102932, 32'd445806934, 32'd3055654640, 32'd897898279,
		32'd3234007399, 32'd1325494930, 32'd2982247189, 32'd1619020475, 32'd2720040856,
		32'd885096170, 32'd3485255499, 32'd2983202469, 32'd3891011124, 32'd546522756,
		32'd1524439205, 32'd2644317889, 32'd2170076800, 32'd2969618716, 32'd961183518,
		32'd1081831074, 32'd1037015347, 32'd3289016286, 32'd2331748669, 32'd620887395,
		32'd303042654, 32'd3990027945, 32'd1562756376, 32'd3413341792, 32'd2059647769,
		32'd2823844432, 32'd674595301, 32'd2457639984, 32'd4076754716, 32'd2447737904,
		32'd1583323324, 32'd625627134, 32'd3076006391, 32'd345777990, 32'd1684954145,
		32'd879227329, 32'd3436182180, 32'd1522273219, 32'd3802543817, 32'd1456017040,
		32'd1897819847, 32'd2970081129, 32'd1382576028, 32'd3820044861, 32'd1044428167,
		32'd612252599, 32'd3340478395, 32'd2150613904, 32'd3397625662, 32'd3573635640,
		32'd3432275192
	};

endpackage

[src/trx_if.sv]
// Valid/ready channel interfaces for the table XOR random generator.
// Depends on trx_pkg.
interface trx_req_if;
	import trx_pkg::*;
	logic  valid;
	logic  ready;
	word_t seed;
	byte_t index;
	word_t modulus;

	modport source (output valid, seed, index, modulus, input ready);
	modport sink (input valid, seed, index, modulus, output ready);
endinterface

interface trx_rsp_if;
	import trx_pkg::*;
	logic  valid;
	logic  ready;
	word_t value;
	logic  bad_modulus;

	modport source (output valid, value, bad_modulus, input ready);
	modport sink (input valid, value, bad_modulus, output ready);
endinterface

[src/trx_lookup.sv]
// Front of the pipeline: lane offset add, then the four table reads and XOR.
// Depends on trx_pkg.
module trx_lookup import trx_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  word_t seed,
	input  byte_t index,
	input  word_t modulus,
	output logic  out_valid,
	output div_t  out_data
);

	logic  vld_s1;
	byte_t addr_s1 [Lanes];
	word_t mod_s1;
	logic  bad_s1;
	byte_t addr_d [Lanes];
	word_t mix_d;

	// Add the index to each seed byte, wrapping at 256
	always_comb begin
		for (int k = 0; k < Lanes; k++) begin
			addr_d[k] = seed[k*ByteW +: ByteW] + index;
		end
	end

	// Read the four tables and fold them together
	assign mix_d = TAB0[addr_s1[0]] ^ TAB1[addr_s1[1]] ^ TAB2[addr_s1[2]] ^ TAB3[addr_s1[3]];

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			out_valid <= vld_s1;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (en) begin
			addr_s1          <= addr_d;
			mod_s1           <= modulus;
			bad_s1           <= (modulus == '0);
			out_data.rem     <= '0;
			out_data.num     <= mix_d;
			out_data.modulus <= mod_s1;
			out_data.bad     <= bad_s1;
		end
	end

endmodule

[src/trx_div_stage.sv]
// One restoring-division step: shift in the next dividend bit and subtract
// the divisor when it fits. Depends on trx_pkg.
module trx_div_stage import trx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  div_t in_data,
	output logic out_valid,
	output div_t out_data
);

	logic [WordW:0] shifted;
	logic [WordW:0] diff;
	div_t           nxt;

	// Shift the top dividend bit into the remainder, subtract if it fits
	always_comb begin
		shifted     = {in_data.rem, in_data.num[WordW-1]};
		diff        = shifted - {1'b0, in_data.modulus};
		nxt         = in_data;
		nxt.num     = {in_data.num[WordW-2:0], 1'b0};
		nxt.rem     = diff[WordW] ? shifted[WordW-1:0] : diff[WordW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

[src/table_xor_rand_mod.sv]
// Table XOR random generator: four table words XORed, reduced mod modulus.
// Stages from input transfer to result: 2 lookup stages, 32
// division stages of one quotient bit each, 1 output register.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken. Reset clears every valid bit; no clearing pass.
// Depends on trx_pkg, trx_if, trx_lookup and trx_div_stage.
module table_xor_rand_mod import trx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	trx_req_if.sink   req,
	trx_rsp_if.source rsp
);

	logic en;
	logic vld [WordW+1];
	div_t dat [WordW+1];
	logic out_vld_q;
	word_t value_q;
	logic bad_q;

	// Advance whenever the output register is free or being emptied
	assign en        = !out_vld_q || rsp.ready;
	assign req.ready = en;

	trx_lookup u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req.valid),
		.seed      (req.seed),
		.index     (req.index),
		.modulus   (req.modulus),
		.out_valid (vld[0]),
		.out_data  (dat[0])
	);

	// One stage per quotient bit, most significant first
	for (genvar g = 0; g < WordW; g++) begin : g_div
		trx_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld[g]),
			.in_data   (dat[g]),
			.out_valid (vld[g+1]),
			.out_data  (dat[g+1])
		);
	end

	// Hold the result; force zero on a zero modulus
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld[WordW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= dat[WordW].bad ? '0 : dat[WordW].rem;
			bad_q   <= dat[WordW].bad;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.value       = value_q;
	assign rsp.bad_modulus = bad_q;

`ifndef NO_ASSERTIONS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.bad_modulus |-> rsp.value == '0)
		else $error("flagged result is not zero");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == (!rsp.valid || rsp.ready))
		else $error("input ready does not follow output stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld[0]) && $stable(vld[WordW]) && $stable(dat[WordW]))
		else $error("pipeline moved during a stall");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld[WordW] && !dat[WordW].bad |-> dat[WordW].rem < dat[WordW].modulus)
		else $error("remainder not below modulus");
`endif

endmodule
